// ----- rtl/ubfr_pkg.sv -----
// Shared types and constants for the UPER bit-field reader.
package ubfr_pkg;

  localparam int BufBytes = 256;
  localparam int CurW = 12;
  localparam logic [CurW-1:0] CursorLimit = 12'hfff;
  localparam logic [CurW:0] BufBits = 13'(BufBytes * 8);

  typedef enum logic [2:0] {
    REQ_LOAD = 3'd0,
    REQ_SEEK = 3'd1,
    REQ_BOOL = 3'd2,
    REQ_CONS = 3'd3,
    REQ_LEN  = 3'd4,
    REQ_UINT = 3'd5,
    REQ_OID  = 3'd6,
    REQ_NONE = 3'd7
  } req_t;

  localparam logic [1:0] ErrNone = 2'd0;
  localparam logic [1:0] ErrBadLen = 2'd1;
  localparam logic [1:0] ErrLong = 2'd2;
  localparam logic [1:0] ErrPastEnd = 2'd3;

  // datapath commands
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,    // capture request, clear work regs
    OP_LOAD,     // write buffer byte
    OP_SEEK,
    OP_WIDTH,    // load bit count of a constrained number
    OP_FETCH,    // read buffer byte at cursor into byte reg
    OP_TAKE,     // shift in nbits bits from byte reg, advance cursor
    OP_LEN_EVAL, // decode first length byte
    OP_LEN2,     // second length byte arrived
    OP_UINT_CHK, // check length for integer
    OP_OID_ACC,  // accumulate oid byte
    OP_FINISH    // form result
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] nbits; // bits to take, 1..8
  } cmd_t;

  typedef struct packed {
    logic       done_bits; // remaining bits zero
    logic       len_two;   // length needs second byte
    logic       oid_more;  // oid continues
    logic       bad;       // integer too long
  } sts_t;

endpackage

// ----- rtl/uper_bit_field_reader_core.sv -----
// Top level of the UPER bit-field reader.
// Sequencing: load, seek and the unused code pass through the start and finish states
//   before the result is valid; field reads add a fetch and a take step per byte slice
//   and one decode step per width, length, integer check and oid byte.
// Throughput: one request at a time; the next transfer can be taken in the cycle after the
//   result transfer, and the result is held in an output register until taken.
// Reset (rst, synchronous) clears cursor and error; the buffer is undefined until loaded.
module uper_bit_field_reader_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         req_type,
  input  logic [7:0]         byte_addr,
  input  logic [7:0]         byte_value,
  input  logic [11:0]        bit_position,
  input  logic signed [63:0] range_min,
  input  logic signed [63:0] range_max,
  input  logic [8:0]         oid_bytes_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] value,
  output logic [11:0]        cursor,
  output logic [1:0]         error_code,
  output logic [8:0]         oid_bytes_out
);
  import ubfr_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [6:0] rem_bits;

  ubfr_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .req_type,
    .rem_bits, .cur_pos(cursor), .sts, .cmd
  );

  ubfr_datapath u_dp (
    .clk, .rst, .cmd, .sts, .req_type, .byte_addr, .byte_value, .bit_position,
    .range_min, .range_max, .oid_bytes_in, .rem_bits, .value, .cursor,
    .error_code, .oid_bytes_out
  );
endmodule

// ----- rtl/ubfr_datapath.sv -----
// Datapath: buffer memory, cursor, bit extractor and field accumulators.
module ubfr_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  ubfr_pkg::cmd_t        cmd,
  output ubfr_pkg::sts_t        sts,
  input  logic [2:0]            req_type,
  input  logic [7:0]            byte_addr,
  input  logic [7:0]            byte_value,
  input  logic [11:0]           bit_position,
  input  logic signed [63:0]    range_min,
  input  logic signed [63:0]    range_max,
  input  logic [8:0]            oid_bytes_in,
  output logic [6:0]            rem_bits,
  output logic signed [63:0]    value,
  output logic [11:0]           cursor,
  output logic [1:0]            error_code,
  output logic [8:0]            oid_bytes_out
);
  import ubfr_pkg::*;

  logic [7:0]  mem [BufBytes];
  logic [7:0]  rd_byte;
  logic [2:0]  req;
  logic [7:0]  ld_addr;
  logic [7:0]  ld_data;
  logic [11:0] seek_pos;
  logic [63:0] rmin;
  logic [63:0] range;
  logic [63:0] acc;
  logic [63:0] comp;
  logic [8:0]  oid_n;
  logic [16:0] len;
  logic        rerr;
  logic [12:0] pos;
  logic [6:0]  width;
  logic [63:0] take_v;
  logic [12:0] take_pos;
  logic        take_err;

  // bit length of the range, by priority search over 64 bits
  always_comb begin
    width = 7'd0;
    for (int i = 0; i < 64; i++) begin
      if (range[i]) width = 7'(i + 1);
    end
  end

  always_comb begin
    take_v = acc;
    take_pos = pos;
    take_err = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < cmd.nbits) begin
        if (take_pos < BufBits) begin
          take_v = {take_v[62:0], rd_byte[3'(7 - 32'(take_pos[2:0]))]};
        end else begin
          take_v = {take_v[62:0], 1'b0};
          take_err = 1'b1;
        end
        take_pos = take_pos + 13'd1;
      end
    end
  end

  assign sts.done_bits = (rem_bits == 7'd0);
  assign sts.len_two = (acc[7:6] == 2'b10);
  assign sts.oid_more = acc[7] && (oid_n > 9'd1);
  assign sts.bad = (len > 17'd8);

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FETCH) rd_byte <= mem[pos[10:3]];
    if (cmd.op == OP_LOAD) mem[ld_addr] <= ld_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      error_code <= ErrNone;
      cursor <= '0;
      value <= '0;
      oid_bytes_out <= '0;
      rerr <= 1'b0;
      req <= REQ_NONE;
      rem_bits <= '0;
    end else begin
      unique case (cmd.op)
        OP_LATCH: begin
          req <= req_type;
          ld_addr <= byte_addr;
          ld_data <= byte_value;
          seek_pos <= bit_position;
          rmin <= range_min;
          range <= range_max - range_min;
          oid_n <= oid_bytes_in;
          acc <= '0;
          comp <= '0;
          len <= '0;
          rerr <= 1'b0;
          pos <= {1'b0, cursor};
          unique case (req_type)
            REQ_BOOL: rem_bits <= 7'd1;
            REQ_LEN, REQ_UINT: rem_bits <= 7'd8;
            REQ_OID: rem_bits <= (oid_bytes_in != 9'd0) ? 7'd8 : 7'd0;
            default: rem_bits <= 7'd0;
          endcase
        end
        OP_LOAD: ;
        OP_SEEK: pos <= {1'b0, seek_pos};
        OP_WIDTH: rem_bits <= width;
        OP_NOP: ;
        OP_FETCH: ;
        OP_TAKE: begin
          acc <= take_v;
          pos <= take_pos;
          rem_bits <= rem_bits - 7'(cmd.nbits);
          if (take_err) begin
            rerr <= 1'b1;
            error_code <= ErrPastEnd;
          end
        end
        OP_LEN_EVAL: begin
          if (!acc[7]) begin
            len <= {9'd0, acc[7:0]};
          end else if (acc[7:6] == 2'b10) begin
            rem_bits <= 7'd8;
            acc <= {57'd0, acc[6:0]};
          end else if (acc[7:0] >= 8'hc1 && acc[7:0] <= 8'hc4) begin
            len <= 17'(acc[2:0]) << 14;
          end else begin
            len <= '0;
            rerr <= 1'b1;
            error_code <= ErrBadLen;
          end
        end
        OP_LEN2: len <= {2'd0, acc[14:0]};
        OP_UINT_CHK: begin
          acc <= '0;
          if (len > 17'd8) begin
            rerr <= 1'b1;
            error_code <= ErrLong;
          end else begin
            rem_bits <= 7'({len[3:0], 3'b000});
          end
        end
        OP_OID_ACC: begin
          comp <= {comp[56:0], acc[6:0]};
          oid_n <= oid_n - 9'd1;
          if (acc[7] && oid_n != 9'd1) rem_bits <= 7'd8;
          acc <= {56'd0, acc[7:0]};
        end
        OP_FINISH: begin
          cursor <= (pos > 13'(CursorLimit)) ? CursorLimit : pos[11:0];
          oid_bytes_out <= (req == REQ_OID) ? oid_n : 9'd0;
          if (rerr) value <= '0;
          else begin
            case (req)
              REQ_BOOL: value <= acc;
              REQ_CONS: value <= acc + rmin;
              REQ_LEN: value <= {47'd0, len};
              REQ_UINT: value <= acc;
              REQ_OID: value <= comp;
              default: value <= '0;
            endcase
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- rtl/ubfr_ctrl.sv -----
// Controller: sequences fetch/take steps per request type.
module ubfr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  logic [2:0]       req_type,
  input  logic [6:0]       rem_bits,
  input  logic [11:0]      cur_pos,
  input  ubfr_pkg::sts_t   sts,
  output ubfr_pkg::cmd_t   cmd
);
  import ubfr_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_START = 11'b00000000010,
    S_WID   = 11'b00000000100,
    S_FETCH = 11'b00000001000,
    S_TAKE  = 11'b00000010000,
    S_LEN   = 11'b00000100000,
    S_LEN2  = 11'b00001000000,
    S_UCHK  = 11'b00010000000,
    S_OID   = 11'b00100000000,
    S_FIN   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic [2:0] req;
  logic [1:0] phase; // 0 first length byte, 1 second length byte, 2 payload
  logic [1:0] phase_next;
  logic [12:0] bpos;
  logic [3:0]  avail;
  logic        in_acc;

  assign in_stall = (state != S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign out_valid = (state == S_OUT);

  // track cursor bit offset locally to size each take
  assign avail = 4'd8 - {1'b0, bpos[2:0]};

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd.op = OP_NOP;
    cmd.nbits = 4'd0;
    unique case (state)
      S_IDLE: if (in_acc) begin
        cmd.op = OP_LATCH;
        state_next = S_START;
      end
      S_START: begin
        phase_next = 2'd0;
        unique case (req)
          REQ_LOAD: begin cmd.op = OP_LOAD; state_next = S_FIN; end
          REQ_SEEK: begin cmd.op = OP_SEEK; state_next = S_FIN; end
          REQ_CONS: begin
            phase_next = 2'd2;
            state_next = S_WID;
          end
          REQ_BOOL: begin phase_next = 2'd2; state_next = S_FETCH; end
          REQ_LEN, REQ_UINT, REQ_OID: state_next = S_FETCH;
          default: state_next = S_FIN;
        endcase
      end
      S_WID: begin
        cmd.op = OP_WIDTH; // datapath loads width
        state_next = S_FETCH;
      end
      S_FETCH: begin
        if (sts.done_bits) begin
          state_next = S_FIN;
        end else begin
          cmd.op = OP_FETCH;
          state_next = S_TAKE;
        end
      end
      S_TAKE: begin
        cmd.op = OP_TAKE;
        cmd.nbits = ({3'd0, avail} < rem_bits) ? avail : rem_bits[3:0];
        if (({3'd0, avail} >= rem_bits)) begin
          if (req == REQ_OID) state_next = S_OID;
          else if (phase == 2'd0) state_next = S_LEN;
          else if (phase == 2'd1) state_next = S_LEN2;
          else state_next = S_FIN;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_LEN: begin
        cmd.op = OP_LEN_EVAL;
        if (sts.len_two) begin
          phase_next = 2'd1;
          state_next = S_FETCH;
        end else if (req == REQ_UINT) state_next = S_UCHK;
        else state_next = S_FIN;
      end
      S_LEN2: begin
        cmd.op = OP_LEN2;
        state_next = (req == REQ_UINT) ? S_UCHK : S_FIN;
      end
      S_UCHK: begin
        cmd.op = OP_UINT_CHK;
        phase_next = 2'd2;
        state_next = sts.bad ? S_FIN : S_FETCH;
      end
      S_OID: begin
        cmd.op = OP_OID_ACC;
        state_next = sts.oid_more ? S_FETCH : S_FIN;
      end
      S_FIN: begin
        cmd.op = OP_FINISH;
        state_next = S_OUT;
      end
      S_OUT: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 2'd0;
      req <= REQ_NONE;
      bpos <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      if (in_acc) req <= req_type;
      if (state == S_START) bpos <= {1'b0, cur_pos};
      if (cmd.op == OP_TAKE) bpos <= bpos + 13'(cmd.nbits);
    end
  end

  assert property (@(posedge clk) disable iff (rst) in_acc |=> state == S_START)
    else $error("accept did not start a request");
  assert property (@(posedge clk) disable iff (rst) out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (rst) cmd.op == OP_TAKE |-> cmd.nbits != 4'd0)
    else $error("empty take");
endmodule

// ----- dv/tb_uper_bit_field_reader_core.sv -----
// Self-checking testbench for the UPER bit-field reader core.
module tb_uper_bit_field_reader_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ubfr_pkg::*;

  typedef struct {
    req_t               req;
    logic [7:0]         addr;
    logic [7:0]         data;
    logic [11:0]        pos;
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    logic [8:0]         oid_n;
    bit                 typed;
    logic signed [63:0] t_value;
    logic [11:0]        t_cursor;
    logic [1:0]         t_err;
  } request_s;

  typedef struct {
    logic signed [63:0] value;
    logic [11:0]        cursor;
    logic [1:0]         err;
    logic [8:0]         oid_left;
  } field_s;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] req_type = '0;
  logic [7:0] byte_addr = '0;
  logic [7:0] byte_value = '0;
  logic [11:0] bit_position = '0;
  logic signed [63:0] range_min = '0;
  logic signed [63:0] range_max = '0;
  logic [8:0] oid_bytes_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [63:0] value;
  logic [11:0] cursor;
  logic [1:0] error_code;
  logic [8:0] oid_bytes_out;

  // typed expectation that rides with the request on the bus
  bit                 cur_typed = 0;
  logic signed [63:0] cur_t_value = '0;
  logic [11:0]        cur_t_cursor = '0;
  logic [1:0]         cur_t_err = '0;

  uper_bit_field_reader_core dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mirror of the block state
  logic [7:0]  msg_mem [BufBytes];
  int          bit_cur = 0;
  logic [1:0]  sticky_err = ErrNone;
  int          rd_pos;
  bit          rd_fail;

  field_s      pending_fields [$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          long_hold = 0;
  bit          hold_fired = 0;
  bit          drain_done = 0;

  function automatic logic [63:0] grab_bits(int n);
    logic [63:0] v = '0;
    logic        b;
    for (int i = 0; i < n; i++) begin
      b = 1'b0;
      if (rd_pos < BufBytes * 8) b = msg_mem[rd_pos >> 3][7 - (rd_pos & 7)];
      else begin
        sticky_err = ErrPastEnd;
        rd_fail = 1;
      end
      v = {v[62:0], b};
      rd_pos++;
    end
    return v;
  endfunction

  function automatic int grab_length();
    int b = int'(grab_bits(8));
    if ((b & 8'h80) == 0) return b;
    if ((b & 8'hc0) == 8'h80) return ((b & 8'h7f) << 8) | int'(grab_bits(8));
    if (b >= 8'hc1 && b <= 8'hc4) return (b - 8'hc0) * 16384;
    sticky_err = ErrBadLen;
    rd_fail = 1;
    return 0;
  endfunction

  function automatic field_s decode_field(request_s r);
    field_s      f;
    logic [63:0] span;
    int          w, len, n, b;
    logic [63:0] acc;
    f.value = '0;
    f.oid_left = '0;
    rd_pos = bit_cur;
    rd_fail = 0;
    case (r.req)
      REQ_LOAD: msg_mem[r.addr] = r.data;
      REQ_SEEK: rd_pos = r.pos;
      REQ_BOOL: f.value = grab_bits(1);
      REQ_CONS: begin
        span = r.hi - r.lo;
        w = 0;
        while (span != 0) begin
          w++;
          span = span >> 1;
        end
        f.value = grab_bits(w) + r.lo;
      end
      REQ_LEN: f.value = grab_length();
      REQ_UINT: begin
        len = grab_length();
        if (len > 8) begin
          sticky_err = ErrLong;
          rd_fail = 1;
        end else f.value = grab_bits(8 * len);
      end
      REQ_OID: begin
        n = r.oid_n;
        acc = '0;
        while (n != 0) begin
          b = int'(grab_bits(8));
          n--;
          acc = (acc << 7) + (b & 8'h7f);
          if ((b & 8'h80) == 0) break;
        end
        f.value = acc;
        f.oid_left = n[8:0];
      end
      default: ;
    endcase
    if (r.req == REQ_LOAD || r.req == REQ_SEEK || rd_fail) f.value = '0;
    bit_cur = rd_pos > int'(CursorLimit) ? int'(CursorLimit) : rd_pos;
    f.cursor = bit_cur[11:0];
    f.err = sticky_err;
    return f;
  endfunction

  // sample at the falling edge: the transfer happens at the next rising edge
  always @(negedge clk) begin
    request_s r;
    field_s   f, e;
    if (!rst && in_valid && !in_stall) begin
      r.req = req_t'(req_type);
      r.addr = byte_addr;
      r.data = byte_value;
      r.pos = bit_position;
      r.lo = range_min;
      r.hi = range_max;
      r.oid_n = oid_bytes_in;
      f = decode_field(r);
      if (cur_typed) begin
        f.value = cur_t_value;
        f.cursor = cur_t_cursor;
        f.err = cur_t_err;
      end
      pending_fields = {pending_fields, f};
    end
    if (!rst && out_valid && !out_stall) begin
      if (pending_fields.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result value=%0d cursor=%0d", value, cursor);
      end else begin
        e = pending_fields.pop_front();
        if (value !== e.value || cursor !== e.cursor || error_code !== e.err ||
            oid_bytes_out !== e.oid_left) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp val=%0d cur=%0d err=%0d oid=%0d got %0d %0d %0d %0d",
                     e.value, e.cursor, e.err, e.oid_left,
                     value, cursor, error_code, oid_bytes_out);
        end
      end
    end
  end

  // receiver: short random stalls, one long hold-off on request
  int hold_left = 0;
  always @(posedge clk) begin
    if (long_hold && hold_left == 0) begin
      hold_left <= 400;
      long_hold <= 0;
      out_stall <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      hold_left <= 0;
      if (cycles % 2000 < 300) out_stall <= 1'b0;
      else if ($urandom_range(0, 19) == 0) out_stall <= 1'b1;
      else out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  request_s plan [$];
  int       sent = 0;

  function automatic void plan_row(request_s r);
    plan = {plan, r};
  endfunction

  function automatic request_s mk(req_t q, int a = 0, int d = 0, int p = 0,
                                  logic signed [63:0] lo = 0, logic signed [63:0] hi = 0,
                                  int n = 0);
    request_s r;
    r.req = q;
    r.addr = a[7:0];
    r.data = d[7:0];
    r.pos = p[11:0];
    r.lo = lo;
    r.hi = hi;
    r.oid_n = n[8:0];
    r.typed = 0;
    r.t_value = '0;
    r.t_cursor = '0;
    r.t_err = '0;
    return r;
  endfunction

  function automatic request_s typed(request_s r, logic signed [63:0] v, int c, logic [1:0] e);
    r.typed = 1;
    r.t_value = v;
    r.t_cursor = c[11:0];
    r.t_err = e;
    return r;
  endfunction

  task automatic send(request_s r);
    bit stalled;
    int gap = 0;
    if (cycles % 3000 >= 400)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= r.req;
    byte_addr <= r.addr;
    byte_value <= r.data;
    bit_position <= r.pos;
    range_min <= r.lo;
    range_max <= r.hi;
    oid_bytes_in <= r.oid_n;
    cur_typed <= r.typed;
    cur_t_value <= r.t_value;
    cur_t_cursor <= r.t_cursor;
    cur_t_err <= r.t_err;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    sent++;
  endtask

  function automatic logic signed [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    int a, len, k;
    request_s r;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the whole buffer so no read ever touches an unloaded byte
    for (int i = 0; i < BufBytes; i++) send(mk(REQ_LOAD, i, $urandom_range(0, 255)));

    plan_row(mk(REQ_LOAD, 0, 8'hff));
    plan_row(mk(REQ_LOAD, 1, 8'h00));
    plan_row(mk(REQ_LOAD, 2, 8'hc0));
    plan_row(mk(REQ_LOAD, 3, 8'h09));
    plan_row(mk(REQ_LOAD, 4, 8'hc3));
    plan_row(mk(REQ_LOAD, 5, 8'h82));
    plan_row(mk(REQ_LOAD, 6, 8'h01));
    plan_row(mk(REQ_SEEK, 0, 0, 0));
    plan_row(typed(mk(REQ_BOOL), 1, 1, ErrNone));
    plan_row(mk(REQ_SEEK, 0, 0, 8));
    plan_row(typed(mk(REQ_BOOL), 0, 9, ErrNone));
    plan_row(typed(mk(REQ_CONS, 0, 0, 0, -5, -5), -5, 9, ErrNone));
    plan_row(mk(REQ_CONS, 0, 0, 0, 64'sh8000000000000000, 64'sh7fffffffffffffff));
    plan_row(mk(REQ_CONS, 0, 0, 0, 5, 3));
    plan_row(mk(REQ_SEEK, 0, 0, 16));
    plan_row(typed(mk(REQ_LEN), 0, 24, ErrBadLen));
    plan_row(typed(mk(REQ_UINT), 0, 32, ErrLong));
    plan_row(mk(REQ_LEN));
    plan_row(mk(REQ_LEN));
    plan_row(mk(REQ_SEEK, 0, 0, 40));
    plan_row(mk(REQ_OID, 0, 0, 0, 0, 0, 2));
    plan_row(mk(REQ_OID, 0, 0, 0, 0, 0, 0));
    plan_row(mk(REQ_OID, 0, 0, 0, 0, 0, 256));
    plan_row(mk(REQ_SEEK, 0, 0, 2048));
    plan_row(typed(mk(REQ_BOOL), 0, 2049, ErrPastEnd));
    plan_row(mk(REQ_SEEK, 0, 0, 4095));
    plan_row(mk(REQ_UINT));
    plan_row(mk(REQ_NONE));
    plan_row(mk(REQ_LOAD, 255, 8'ha5));
    foreach (plan[i]) send(plan[i]);

    while (sent < 1200) begin
      if (sent > 700 && !hold_fired) begin
        long_hold = 1;
        hold_fired = 1;
      end
      if (sent > 1100 && !drain_done) begin
        // pause until the block has drained
        drain_done = 1;
        in_valid <= 1'b0;
        cur_typed <= 0;
        while (pending_fields.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
      end
      a = $urandom_range(0, 239);
      case ($urandom_range(0, 7))
        0: begin // well-formed unconstrained integer
          len = $urandom_range(0, 8);
          send(mk(REQ_LOAD, a, len));
          for (int i = 1; i <= len; i++) send(mk(REQ_LOAD, a + i, $urandom_range(0, 255)));
          send(mk(REQ_SEEK, 0, 0, a * 8 + $urandom_range(0, 1) * 0));
          send(mk(REQ_UINT));
        end
        1: begin // well-formed oid component
          len = $urandom_range(1, 10);
          for (int i = 0; i < len; i++)
            send(mk(REQ_LOAD, a + i, {(i != len - 1), 7'($urandom())}));
          send(mk(REQ_SEEK, 0, 0, a * 8));
          k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(len, len + 3);
          send(mk(REQ_OID, 0, 0, 0, 0, 0, k));
        end
        2: begin
          send(mk(REQ_SEEK, 0, 0, $urandom_range(0, 2047)));
          k = $urandom_range(0, 1);
          send(mk(k ? REQ_LEN : REQ_UINT));
        end
        3: begin
          r = mk(REQ_CONS);
          r.lo = rnd64();
          r.hi = ($urandom_range(0, 3) == 0) ? rnd64() : r.lo + $urandom_range(0, 300);
          if ($urandom_range(0, 4) == 0) begin
            r.lo = 0;
            r.hi = 127;
          end
          send(mk(REQ_SEEK, 0, 0, $urandom_range(0, 2047)));
          send(r);
        end
        4: send(mk(REQ_BOOL));
        5: send(mk(REQ_SEEK, 0, 0, ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 2047)));
        6: send(mk(REQ_LOAD, $urandom(), $urandom()));
        default: send(mk(req_t'($urandom_range(2, 7)), 0, 0, 0, rnd64(), rnd64(),
                         $urandom_range(0, 511)));
      endcase
    end

    in_valid <= 1'b0;
    while (pending_fields.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
